// File: design/stereo_box_match_depth_unit_defines.svh
// Assertion macros used by the stereo box match and depth top-level design file.
`ifndef STEREO_BOX_MATCH_DEPTH_UNIT_DEFINES_SVH
`define STEREO_BOX_MATCH_DEPTH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBMD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBMD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sbmd_pkg.sv
// Shared types and constants for the stereo box match and depth unit.
`default_nettype none
package sbmd_pkg;

	// Divider geometry: 16-bit disparity, 24-bit quotient, two bits per stage.
	localparam int DIVISOR_W          = 16;
	localparam int QUOT_W             = 24;
	localparam int DIV_BITS_PER_STAGE = 2;
	localparam int DIV_STAGES         = QUOT_W / DIV_BITS_PER_STAGE;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MARGIN        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_MARGIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_BASELINE = 3'd5;

	// Reject cause codes.
	typedef enum logic [1:0] {
		CAUSE_OK     = 2'd0,
		CAUSE_HEIGHT = 2'd1,
		CAUSE_BORDER = 2'd2
	} cause_t;

	// Side information that rides along with a division.
	typedef struct packed {
		cause_t cause;
		logic   disp_pos;
		logic   ovf;
	} sbmd_tag_t;

endpackage
`default_nettype wire

// File: design/stereo_box_match_depth_unit.sv
// Stereo box pair check and depth triangulation, top level.
// A pair passes stage 1, stage 2, the 12 divider stages and the output register.
// Throughput: one pair per cycle while no held result is stalled at the output.
// A stalled output freezes every stage; the input stalls only while it is frozen.
// Reset clears all valid bits and loads the configuration registers with defaults.
`default_nettype none
`include "stereo_box_match_depth_unit_defines.svh"
module stereo_box_match_depth_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [sbmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                    cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [15:0]                    left_center_x,
	input  wire logic [15:0]                    left_center_y,
	input  wire logic [15:0]                    left_width,
	input  wire logic [15:0]                    left_height,
	input  wire logic [15:0]                    right_center_x,
	input  wire logic [15:0]                    right_center_y,
	input  wire logic [15:0]                    right_width,
	input  wire logic [15:0]                    right_height,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                accepted,
	output logic [1:0]                          reject_cause,
	output logic [23:0]                         depth,
	output logic                                depth_valid
);
	import sbmd_pkg::*;

	// Exact border test; all terms moved to one side so nothing goes negative.
	function automatic logic near_border(
		input logic [15:0] cx, input logic [15:0] cy,
		input logic [15:0] w,  input logic [15:0] h,
		input logic [15:0] m,  input logic [11:0] iw, input logic [11:0] ih);
		logic [18:0] two_c;
		logic [18:0] two_cy;
		logic [18:0] two_m;
		logic [18:0] lim_w;
		logic [18:0] lim_h;
		logic        near_l;
		logic        near_r;
		logic        near_b;
		two_c  = {2'b00, cx, 1'b0};
		two_cy = {2'b00, cy, 1'b0};
		two_m  = {2'b00, m, 1'b0};
		lim_w  = {2'b00, iw, 5'b0};
		lim_h  = {2'b00, ih, 5'b0};
		near_l = two_c < ({3'b000, w} + two_m);
		near_r = (two_c + {3'b000, w} + two_m) > lim_w;
		near_b = (two_cy + {3'b000, h} + two_m) > lim_h;
		return near_l || near_r || near_b;
	endfunction

	// Configuration registers.
	logic [15:0] y_margin_q;
	logic [15:0] border_margin_q;
	logic [11:0] image_width_q;
	logic [11:0] image_height_q;
	logic [15:0] focal_x_q;
	logic [15:0] stereo_baseline_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_margin_q        <= 16'd320;
			border_margin_q   <= 16'd0;
			image_width_q     <= 12'd640;
			image_height_q    <= 12'd480;
			focal_x_q         <= 16'd8000;
			stereo_baseline_q <= 16'd100;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_Y_MARGIN:        y_margin_q        <= cfg_data;
				REG_BORDER_MARGIN:   border_margin_q   <= cfg_data;
				REG_IMAGE_WIDTH:     image_width_q     <= cfg_data[11:0];
				REG_IMAGE_HEIGHT:    image_height_q    <= cfg_data[11:0];
				REG_FOCAL_X:         focal_x_q         <= cfg_data;
				REG_STEREO_BASELINE: stereo_baseline_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Global advance: everything moves unless a finished result is held.
	logic out_valid_q;
	logic en;
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// Stage 1: geometry tests, disparity and the baseline-focal product.
	logic        valid_s1;
	logic        bad_height_s1;
	logic        bad_border_s1;
	logic        disp_pos_s1;
	logic [15:0] disp_s1;
	logic [31:0] prod_s1;
	logic [15:0] dy;
	logic [15:0] disp_full;

	always_comb begin
		dy = (left_center_y >= right_center_y) ? (left_center_y - right_center_y)
		                                       : (right_center_y - left_center_y);
		disp_full = left_center_x - right_center_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_height_s1 <= dy > y_margin_q;
			bad_border_s1 <= near_border(left_center_x, left_center_y, left_width,
			                             left_height, border_margin_q, image_width_q,
			                             image_height_q)
			              || near_border(right_center_x, right_center_y, right_width,
			                             right_height, border_margin_q, image_width_q,
			                             image_height_q);
			disp_pos_s1   <= left_center_x > right_center_x;
			disp_s1       <= disp_full;
			prod_s1       <= stereo_baseline_q * focal_x_q;
		end
	end

	// Stage 2: overflow check and cause selection; the quotient saturates when
	// the upper half of the numerator already reaches the divisor.
	logic                 valid_s2;
	sbmd_tag_t            tag_s2;
	logic [15:0]          rem_s2;
	logic [QUOT_W-1:0]    dvd_s2;
	logic [DIVISOR_W-1:0] dsr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2.cause    <= bad_height_s1 ? CAUSE_HEIGHT
			                 : (bad_border_s1 ? CAUSE_BORDER : CAUSE_OK);
			tag_s2.disp_pos <= disp_pos_s1;
			tag_s2.ovf      <= prod_s1[31:16] >= disp_s1;
			rem_s2          <= prod_s1[31:16];
			dvd_s2          <= {prod_s1[15:0], 8'h00};
			dsr_s2          <= disp_s1;
		end
	end

	// Division stages.
	logic              div_valid;
	logic [QUOT_W-1:0] div_quot;
	sbmd_tag_t         div_tag;

	sbmd_div_pipe u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_in    (valid_s2),
		.rem_in      (rem_s2),
		.dividend_in (dvd_s2),
		.divisor_in  (dsr_s2),
		.tag_in      (tag_s2),
		.valid_out   (div_valid),
		.quot_out    (div_quot),
		.tag_out     (div_tag)
	);

	// Output register: final depth selection.
	logic              accepted_q;
	cause_t            cause_q;
	logic [QUOT_W-1:0] depth_q;
	logic              depth_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			accepted_q    <= div_tag.cause == CAUSE_OK;
			cause_q       <= div_tag.cause;
			depth_valid_q <= div_tag.disp_pos;
			if (!div_tag.disp_pos) begin
				depth_q <= '0;
			end else if (div_tag.ovf) begin
				depth_q <= '1;
			end else begin
				depth_q <= div_quot;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = accepted_q;
	assign reject_cause = cause_q;
	assign depth        = depth_q;
	assign depth_valid  = depth_valid_q;

	`SBMD_ASSERT_IMP(a_depth_zero_when_invalid, clk, arst_n, out_valid && !depth_valid, depth == 24'd0, "depth nonzero with depth_valid low")
	`SBMD_ASSERT_IMP(a_cause_legal, clk, arst_n, out_valid, reject_cause == CAUSE_OK || reject_cause == CAUSE_HEIGHT || reject_cause == CAUSE_BORDER, "illegal reject cause")
	`SBMD_ASSERT_IMP(a_accept_matches_cause, clk, arst_n, out_valid, accepted == (reject_cause == CAUSE_OK), "accepted disagrees with reject cause")
	`SBMD_ASSERT_NXT(a_held_result_frozen, clk, arst_n, out_valid && out_stall, !in_stall || $stable(depth), "held result changed under stall")

endmodule
`default_nettype wire

// File: design/sbmd_div_pipe.sv
// Pipelined restoring divider, two quotient bits per stage, with a side tag.
`default_nettype none
module sbmd_div_pipe (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           valid_in,
	input  wire logic [sbmd_pkg::DIVISOR_W-1:0] rem_in,
	input  wire logic [sbmd_pkg::QUOT_W-1:0]    dividend_in,
	input  wire logic [sbmd_pkg::DIVISOR_W-1:0] divisor_in,
	input  wire sbmd_pkg::sbmd_tag_t            tag_in,
	output logic                                valid_out,
	output logic [sbmd_pkg::QUOT_W-1:0]         quot_out,
	output sbmd_pkg::sbmd_tag_t                 tag_out
);
	import sbmd_pkg::*;

	typedef struct packed {
		logic [DIVISOR_W-1:0] rem;
		logic [QUOT_W-1:0]    dvd;
		logic [QUOT_W-1:0]    quo;
		logic [DIVISOR_W-1:0] dsr;
		sbmd_tag_t            tag;
	} div_st_t;

	// One stage of restoring division: shift in dividend bits, subtract when it fits.
	function automatic div_st_t div_step(input div_st_t st);
		div_st_t            nx;
		logic [DIVISOR_W:0] trial;
		logic               qbit;
		nx = st;
		for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
			trial = {nx.rem, nx.dvd[QUOT_W-1]};
			nx.dvd = {nx.dvd[QUOT_W-2:0], 1'b0};
			qbit = (trial >= {1'b0, nx.dsr});
			if (qbit) begin
				trial = trial - {1'b0, nx.dsr};
			end
			nx.rem = trial[DIVISOR_W-1:0];
			nx.quo = {nx.quo[QUOT_W-2:0], qbit};
		end
		return nx;
	endfunction

	div_st_t st_in [DIV_STAGES];
	div_st_t st_s  [DIV_STAGES];
	logic    vin   [DIV_STAGES];
	logic    v_s   [DIV_STAGES];

	// Entry of the first stage.
	always_comb begin
		st_in[0].rem = rem_in;
		st_in[0].dvd = dividend_in;
		st_in[0].quo = '0;
		st_in[0].dsr = divisor_in;
		st_in[0].tag = tag_in;
		vin[0]       = valid_in;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		if (k > 0) begin : g_link
			assign st_in[k] = st_s[k-1];
			assign vin[k]   = v_s[k-1];
		end

		// Valid bit of the stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vin[k];
			end
		end

		// Stage payload moves only when the pipeline advances.
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= div_step(st_in[k]);
			end
		end
	end

	assign valid_out = v_s[DIV_STAGES-1];
	assign quot_out  = st_s[DIV_STAGES-1].quo;
	assign tag_out   = st_s[DIV_STAGES-1].tag;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stereo box pair check and depth unit.

import sbmd_pkg::*;

// One left/right detection pair as presented on the input ports.
typedef struct packed {
	logic [15:0] lx;
	logic [15:0] ly;
	logic [15:0] lw;
	logic [15:0] lh;
	logic [15:0] rx;
	logic [15:0] ry;
	logic [15:0] rw;
	logic [15:0] rh;
} box_pair_t;

// One result as seen on the output ports.
typedef struct packed {
	logic        accepted;
	cause_t      cause;
	logic [23:0] depth;
	logic        depth_valid;
} depth_result_t;

// Predicts the match verdict and depth of each pair and checks results in order.
class depth_scoreboard;
	logic [15:0] y_margin;
	logic [15:0] border_margin;
	logic [11:0] image_width;
	logic [11:0] image_height;
	logic [15:0] focal_x;
	logic [15:0] stereo_baseline;
	depth_result_t due_results[$];
	int errors;

	function new();
		y_margin        = 16'd320;
		border_margin   = 16'd0;
		image_width     = 12'd640;
		image_height    = 12'd480;
		focal_x         = 16'd8000;
		stereo_baseline = 16'd100;
		errors          = 0;
	endfunction

	// Mirror a register write; narrow registers keep only their low bits.
	function void write_reg(logic [CFG_IDX_W-1:0] index, logic [15:0] value);
		case (index)
			REG_Y_MARGIN:        y_margin = value;
			REG_BORDER_MARGIN:   border_margin = value;
			REG_IMAGE_WIDTH:     image_width = value[11:0];
			REG_IMAGE_HEIGHT:    image_height = value[11:0];
			REG_FOCAL_X:         focal_x = value;
			REG_STEREO_BASELINE: stereo_baseline = value;
			default: ;
		endcase
	endfunction

	// A box is too near when it reaches within the margin of the left, right or bottom edge.
	function bit near_edge(longint cx, longint cy, longint w, longint h);
		longint m2;
		longint wlim;
		longint hlim;
		m2   = 2 * longint'(border_margin);
		wlim = 32 * longint'(image_width) - m2;
		hlim = 32 * longint'(image_height) - m2;
		return (2 * cx - w < m2) || (2 * cx + w > wlim) || (2 * cy + h > hlim);
	endfunction

	function depth_result_t predict_match_depth(box_pair_t p);
		depth_result_t r;
		longint dy;
		longint disp;
		longint unsigned num;
		longint unsigned quot;
		dy = longint'(p.ly) - longint'(p.ry);
		if (dy < 0) begin
			dy = -dy;
		end
		// A height mismatch outranks a border violation.
		if (dy > longint'(y_margin)) begin
			r.cause = CAUSE_HEIGHT;
		end else if (near_edge(p.lx, p.ly, p.lw, p.lh) || near_edge(p.rx, p.ry, p.rw, p.rh)) begin
			r.cause = CAUSE_BORDER;
		end else begin
			r.cause = CAUSE_OK;
		end
		r.accepted = (r.cause == CAUSE_OK);
		// Depth is computed for rejected pairs as well.
		disp = longint'(p.lx) - longint'(p.rx);
		r.depth = 24'd0;
		r.depth_valid = 1'b0;
		if (disp > 0) begin
			num = stereo_baseline;
			num = num * focal_x * 256;
			quot = num / disp;
			r.depth = (quot > 64'hFFFFFF) ? 24'hFFFFFF : quot[23:0];
			r.depth_valid = 1'b1;
		end
		return r;
	endfunction

	function void note_pair(box_pair_t p);
		due_results.insert(due_results.size(), predict_match_depth(p));
	endfunction

	function int pending();
		return due_results.size();
	endfunction

	function void compare_field(string field, logic [23:0] want, logic [23:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	function void check_result(depth_result_t got);
		depth_result_t want;
		if (due_results.size() == 0) begin
			$display("%0t ns: result with no pair waiting, expected none, actual %0d/%0d/%0d/%0d",
				$time, got.accepted, got.cause, got.depth, got.depth_valid);
			errors++;
			return;
		end
		want = due_results.pop_front();
		compare_field("accepted", 24'(want.accepted), 24'(got.accepted));
		compare_field("reject_cause", 24'(want.cause), 24'(got.cause));
		compare_field("depth", want.depth, got.depth);
		compare_field("depth_valid", 24'(want.depth_valid), 24'(got.depth_valid));
	endfunction
endclass

module testbench;
	localparam int LATENCY         = 15;
	localparam int CYCLE_LIMIT     = 100000;
	localparam int PHASES          = 8;
	localparam int PAIRS_PER_PHASE = 130;
	localparam int CALM_PHASE      = 5;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [15:0]          left_center_x = '0;
	logic [15:0]          left_center_y = '0;
	logic [15:0]          left_width = '0;
	logic [15:0]          left_height = '0;
	logic [15:0]          right_center_x = '0;
	logic [15:0]          right_center_y = '0;
	logic [15:0]          right_width = '0;
	logic [15:0]          right_height = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 accepted;
	logic [1:0]           reject_cause;
	logic [23:0]          depth;
	logic                 depth_valid;

	bit              idle_on = 1'b1;
	int              cycle_count = 0;
	depth_scoreboard sb;

	stereo_box_match_depth_unit uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Record accepted pairs and check delivered results at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_pair(box_pair_t'{left_center_x, left_center_y, left_width, left_height,
					right_center_x, right_center_y, right_width, right_height});
			end
			if (out_valid && !out_stall) begin
				sb.check_result(depth_result_t'{accepted, cause_t'(reject_cause), depth,
					depth_valid});
			end
		end
	end

	// The result side stalls at random except in the calm phase.
	always @(negedge clk) begin
		out_stall = arst_n && idle_on && ($urandom_range(99) < 24);
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("stereo_box_match_depth_unit test failed");
			$finish;
		end
	end

	function automatic logic [15:0] clamp16(int v);
		return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
	endfunction

	function automatic box_pair_t pair_of(int lx, int ly, int lw, int lh,
		int rx, int ry, int rw, int rh);
		return box_pair_t'{16'(lx), 16'(ly), 16'(lw), 16'(lh),
			16'(rx), 16'(ry), 16'(rw), 16'(rh)};
	endfunction

	// Mostly plausible pairs inside the image with small disparity and height offset;
	// a quarter are raw noise over the whole field range.
	function automatic box_pair_t random_pair();
		box_pair_t p;
		int wpx;
		int hpx;
		int disp;
		int yspan;
		if ($urandom_range(99) < 25) begin
			p = {$urandom(), $urandom(), $urandom(), $urandom()};
			return p;
		end
		wpx = 16 * int'(sb.image_width);
		hpx = 16 * int'(sb.image_height);
		yspan = int'(sb.y_margin) + 32;
		if (yspan > 4000) begin
			yspan = 4000;
		end
		if ($urandom_range(99) < 8) begin
			disp = -int'($urandom_range(0, 64));
		end else begin
			disp = int'($urandom_range(0, 2400));
		end
		p.lw = 16'($urandom_range(0, 1200));
		p.lh = 16'($urandom_range(0, 1200));
		p.rw = clamp16(int'(p.lw) + int'($urandom_range(0, 64)) - 32);
		p.rh = clamp16(int'(p.lh) + int'($urandom_range(0, 64)) - 32);
		p.lx = 16'($urandom_range(0, wpx));
		p.ly = 16'($urandom_range(0, hpx));
		p.rx = clamp16(int'(p.lx) - disp);
		p.ry = clamp16(int'(p.ly) + int'($urandom_range(0, 2 * yspan)) - yspan);
		return p;
	endfunction

	// Present one pair, with random idle cycles first, and hold it until the transfer.
	task automatic send_pair(box_pair_t p);
		while (idle_on && $urandom_range(99) < 24) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		{left_center_x, left_center_y, left_width, left_height,
			right_center_x, right_center_y, right_width, right_height} = p;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Stop sending and wait until every expected result has been delivered.
	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] index, logic [15:0] value);
		cfg_write = 1'b1;
		cfg_index = index;
		cfg_data = value;
		sb.write_reg(index, value);
		@(negedge clk);
	endtask

	// Register settings per phase; the block is idle when this runs.
	task automatic configure_phase(int ph);
		case (ph)
			1: begin
				write_cfg(REG_Y_MARGIN, 16'd0);
				write_cfg(REG_BORDER_MARGIN, 16'd0);
				write_cfg(REG_IMAGE_WIDTH, 16'd4095);
				write_cfg(REG_IMAGE_HEIGHT, 16'd4095);
				write_cfg(REG_FOCAL_X, 16'hFFFF);
				write_cfg(REG_STEREO_BASELINE, 16'hFFFF);
			end
			2: begin
				write_cfg(REG_Y_MARGIN, 16'hFFFF);
				write_cfg(REG_BORDER_MARGIN, 16'd16);
				write_cfg(REG_IMAGE_WIDTH, 16'd640);
				write_cfg(REG_IMAGE_HEIGHT, 16'd480);
				write_cfg(REG_FOCAL_X, 16'd0);
			end
			3: begin
				write_cfg(REG_Y_MARGIN, 16'd320);
				write_cfg(REG_FOCAL_X, 16'd8000);
				write_cfg(REG_STEREO_BASELINE, 16'd0);
			end
			4: begin
				// Margin wider than the image: every box is too near a border.
				write_cfg(REG_BORDER_MARGIN, 16'hFFFF);
				write_cfg(REG_IMAGE_WIDTH, 16'd1);
				write_cfg(REG_IMAGE_HEIGHT, 16'd1);
				write_cfg(REG_STEREO_BASELINE, 16'd100);
			end
			6: begin
				// Upper bits of the width write are dropped; unused indexes change nothing.
				write_cfg(REG_Y_MARGIN, 16'd320);
				write_cfg(REG_BORDER_MARGIN, 16'd0);
				write_cfg(REG_IMAGE_WIDTH, 16'hF280);
				write_cfg(REG_IMAGE_HEIGHT, 16'd480);
				write_cfg(REG_UNUSED_LO, 16'($urandom()));
				write_cfg(REG_UNUSED_HI, 16'($urandom()));
			end
			default: begin
				write_cfg(REG_Y_MARGIN, 16'($urandom_range(0, 1200)));
				write_cfg(REG_BORDER_MARGIN, 16'($urandom_range(0, 400)));
				write_cfg(REG_IMAGE_WIDTH, 16'($urandom_range(64, 4095)));
				write_cfg(REG_IMAGE_HEIGHT, 16'($urandom_range(64, 4095)));
				write_cfg(REG_FOCAL_X, 16'($urandom()));
				write_cfg(REG_STEREO_BASELINE, 16'($urandom_range(0, 2000)));
			end
		endcase
		cfg_write = 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed pairs under the reset configuration.
		send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(pair_of(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535));
		send_pair(pair_of(3200, 2400, 320, 320, 2880, 2400, 320, 320));
		// Height difference exactly at the margin, then one past it either way.
		send_pair(pair_of(3200, 2400, 320, 320, 2880, 2720, 320, 320));
		send_pair(pair_of(3200, 2400, 320, 320, 2880, 2721, 320, 320));
		send_pair(pair_of(3200, 2721, 320, 320, 2880, 2400, 320, 320));
		// Height and border both fail: the height cause wins.
		send_pair(pair_of(100, 2400, 320, 320, 50, 2800, 320, 320));
		// Negative disparity and a disparity of one, which saturates.
		send_pair(pair_of(2880, 2400, 320, 320, 3200, 2400, 320, 320));
		send_pair(pair_of(3201, 2400, 320, 320, 3200, 2400, 320, 320));
		// Left edge touched, then crossed by one.
		send_pair(pair_of(160, 2400, 320, 320, 100, 2400, 200, 320));
		send_pair(pair_of(160, 2400, 321, 320, 100, 2400, 200, 320));
		// Right edge touched, then crossed by one.
		send_pair(pair_of(10080, 2400, 320, 320, 10000, 2400, 320, 320));
		send_pair(pair_of(10080, 2400, 321, 320, 10000, 2400, 320, 320));
		// Bottom edge touched, then crossed by the right box alone.
		send_pair(pair_of(3200, 7520, 320, 320, 2880, 7520, 320, 320));
		send_pair(pair_of(3200, 7520, 320, 320, 2880, 7520, 320, 321));
		// Largest disparity, and a box above the top edge, which is not tested.
		send_pair(pair_of(65535, 2400, 0, 0, 0, 2400, 0, 0));
		send_pair(pair_of(3200, 10, 320, 320, 2880, 10, 320, 320));

		// Random phases, each under its own register settings.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				configure_phase(ph);
			end
			idle_on = (ph != CALM_PHASE);
			repeat (PAIRS_PER_PHASE) send_pair(random_pair());
		end

		drain();
		repeat (LATENCY + 5) @(posedge clk);
		if (sb.errors == 0) begin
			$display("stereo_box_match_depth_unit test passed");
		end else begin
			$display("stereo_box_match_depth_unit test failed");
		end
		$finish;
	end
endmodule
